// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, stage counts and register codes for the ray/triangle test.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int CW   = 32;           // coordinate / distance width
    localparam int EW   = CW + 1;       // edge and origin offset
    localparam int XW   = 2 * EW + 1;   // cross product terms
    localparam int LW   = 34;           // low slice of a cross term
    localparam int HW   = XW - LW;      // high slice of a cross term
    localparam int PLW  = LW + 1 + EW;  // low partial product
    localparam int PHW  = HW + EW;      // high partial product
    localparam int PW   = 102;          // dot products and sums
    localparam int DW   = 101;          // divider remainder / divisor
    localparam int QW   = 32;           // quotient bits, Q2.30
    localparam int IXW  = 3;

    localparam int DIV0 = 7;            // first divider stage
    localparam int NSTG = DIV0 + QW + 1;

    typedef enum logic [IXW-1:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5
    } cfg_reg_t;

endpackage
`default_nettype wire

// ===== sv/ray_triangle_intersect_top.sv =====
// Throughput: one triangle per cycle while tri_stall is low; 7 arithmetic stages,
// then a 32-stage restoring divider at one quotient bit per stage, then the output register.
// A stalled output fills bubbles upstream before the input stalls.
// Reset clears all valid bits and the ray registers to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Culling ray/triangle test in exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rti_pkg::IXW-1:0]        cfg_index,
    input  wire logic [rti_pkg::CW-1:0]         cfg_data,
    input  wire logic                           tri_valid,
    output logic                                tri_stall,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_a_x,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_a_y,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_a_z,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_b_x,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_b_y,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_b_z,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_c_x,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_c_y,
    input  wire logic signed [rti_pkg::CW-1:0]  vertex_c_z,
    input  wire logic [rti_pkg::CW-1:0]         t_limit,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output logic [rti_pkg::CW-1:0]              hit_distance,
    output logic                                hit
);
    import rti_pkg::*;

    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] dir_reg [3];

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    logic [CW-1:0] lim_reg [DIV0];

    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [EW-1:0]  d_reg  [3];
    logic signed [EW-1:0]  e1_next [3];
    logic signed [EW-1:0]  e2_next [3];
    logic signed [EW-1:0]  d_next  [3];

    logic signed [XW-1:0]  c1a_reg [3];
    logic signed [XW-1:0]  c1b_reg [3];
    logic signed [XW-1:0]  c2a_reg [3];
    logic signed [XW-1:0]  c2b_reg [3];
    logic signed [XW-1:0]  c1a_next [3];
    logic signed [XW-1:0]  c1b_next [3];
    logic signed [XW-1:0]  c2a_next [3];
    logic signed [XW-1:0]  c2b_next [3];
    logic signed [EW-1:0]  e1b_reg [3];
    logic signed [EW-1:0]  e2b_reg [3];
    logic signed [EW-1:0]  db_reg  [3];

    logic signed [XW-1:0]  s1_reg [3];
    logic signed [XW-1:0]  s2_reg [3];
    logic signed [EW-1:0]  e1c_reg [3];
    logic signed [EW-1:0]  e2c_reg [3];
    logic signed [EW-1:0]  dc_reg  [3];

    logic signed [PLW-1:0] plo_reg [4][3];
    logic signed [PHW-1:0] phi_reg [4][3];
    logic signed [PLW-1:0] plo_next [4][3];
    logic signed [PHW-1:0] phi_next [4][3];

    logic signed [PW-1:0]  prd_reg [4][3];
    logic signed [PW-1:0]  prd_next [4][3];

    logic signed [PW-1:0]  dot_reg [4];
    logic signed [PW-1:0]  dot_next [4];

    logic [DW-1:0] t_r_reg;
    logic [DW-1:0] t_d_reg;
    logic          t_h_reg;
    logic [DW-1:0] t_r_next;
    logic [DW-1:0] t_d_next;
    logic          t_h_next;

    logic [DW-1:0] dv_r_reg [QW];
    logic [DW-1:0] dv_d_reg [QW];
    logic [QW-1:0] dv_q_reg [QW];
    logic          dv_h_reg [QW];
    logic [CW-1:0] dv_l_reg [QW];
    logic [DW-1:0] dv_r_next [QW];
    logic [QW-1:0] dv_q_next [QW];

    logic [CW-1:0] hit_distance_reg;
    logic          hit_reg;
    logic [CW-1:0] hit_distance_next;
    logic          hit_next;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORG_X: org_reg[0] <= cfg_data;
                REG_ORG_Y: org_reg[1] <= cfg_data;
                REG_ORG_Z: org_reg[2] <= cfg_data;
                REG_DIR_X: dir_reg[0] <= cfg_data;
                REG_DIR_Y: dir_reg[1] <= cfg_data;
                REG_DIR_Z: dir_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || !res_stall;
        for (int s = NSTG - 2; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    assign tri_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= tri_valid;
            end
            for (int s = 1; s < NSTG; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            lim_reg[0] <= t_limit;
        end
        for (int s = 1; s < DIV0; s++)
        begin
            if (rdy[s])
            begin
                lim_reg[s] <= lim_reg[s-1];
            end
        end
    end

    // stage 0: edges and origin offset
    always_comb
    begin
        e1_next[0] = EW'(vertex_c_x) - EW'(vertex_a_x);
        e1_next[1] = EW'(vertex_c_y) - EW'(vertex_a_y);
        e1_next[2] = EW'(vertex_c_z) - EW'(vertex_a_z);
        e2_next[0] = EW'(vertex_b_x) - EW'(vertex_a_x);
        e2_next[1] = EW'(vertex_b_y) - EW'(vertex_a_y);
        e2_next[2] = EW'(vertex_b_z) - EW'(vertex_a_z);
        d_next[0]  = EW'(org_reg[0]) - EW'(vertex_a_x);
        d_next[1]  = EW'(org_reg[1]) - EW'(vertex_a_y);
        d_next[2]  = EW'(org_reg[2]) - EW'(vertex_a_z);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            d_reg  <= d_next;
        end
    end

    // stage 1: cross product terms, s1 = dir x e2, s2 = d x e1
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            int j;
            int k;
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            c1a_next[i] = XW'(EW'(dir_reg[j]) * e2_reg[k]);
            c1b_next[i] = XW'(EW'(dir_reg[k]) * e2_reg[j]);
            c2a_next[i] = XW'(d_reg[j] * e1_reg[k]);
            c2b_next[i] = XW'(d_reg[k] * e1_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            c1a_reg <= c1a_next;
            c1b_reg <= c1b_next;
            c2a_reg <= c2a_next;
            c2b_reg <= c2b_next;
            e1b_reg <= e1_reg;
            e2b_reg <= e2_reg;
            db_reg  <= d_reg;
        end
    end

    // stage 2: cross products
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i] <= c1a_reg[i] - c1b_reg[i];
                s2_reg[i] <= c2a_reg[i] - c2b_reg[i];
            end
            e1c_reg <= e1b_reg;
            e2c_reg <= e2b_reg;
            dc_reg  <= db_reg;
        end
    end

    // stage 3: split partial products of K, N1, N2, Nt
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [XW-1:0]        w   [4];
            logic signed [EW-1:0] nar [4];
            w[0]   = s1_reg[i];
            w[1]   = s1_reg[i];
            w[2]   = s2_reg[i];
            w[3]   = s2_reg[i];
            nar[0] = e1c_reg[i];
            nar[1] = dc_reg[i];
            nar[2] = EW'(dir_reg[i]);
            nar[3] = e2c_reg[i];
            for (int m = 0; m < 4; m++)
            begin
                plo_next[m][i] = $signed({1'b0, w[m][LW-1:0]}) * nar[m];
                phi_next[m][i] = $signed(w[m][XW-1:LW]) * nar[m];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    // stage 4: join partial products
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prd_next[m][i] = (PW'(phi_reg[m][i]) <<< LW) + PW'(plo_reg[m][i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            prd_reg <= prd_next;
        end
    end

    // stage 5: dot products
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            dot_next[m] = prd_reg[m][0] + prd_reg[m][1] + prd_reg[m][2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            dot_reg <= dot_next;
        end
    end

    // stage 6: culling, barycentric and range tests; divider setup
    always_comb
    begin
        logic signed [PW-1:0] k;
        logic signed [PW-1:0] n1;
        logic signed [PW-1:0] n2;
        logic signed [PW-1:0] nt;
        logic signed [PW-1:0] n12;
        logic signed [PW-1:0] mk;
        logic signed [PW-1:0] mt;
        logic [PW-1:0]        mk4;
        logic                 inside_tri;
        k   = dot_reg[0];
        n1  = dot_reg[1];
        n2  = dot_reg[2];
        nt  = dot_reg[3];
        n12 = n1 + n2;
        mk  = -k;
        mt  = -nt;
        mk4 = $unsigned(mk) << 2;
        inside_tri = !(n1 > 0 || n1 < k || n2 > 0 || n12 < k || nt > 0);
        t_h_next = k[PW-1] && inside_tri && ($unsigned(mt) < mk4);
        t_r_next = mt[DW-1:0];
        t_d_next = {mk[DW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            t_r_reg <= t_r_next;
            t_d_reg <= t_d_next;
            t_h_reg <= t_h_next;
        end
    end

    // divider: one quotient bit per stage against 2*|K|
    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            logic [DW-1:0] r;
            logic [DW-1:0] dv;
            logic [QW-1:0] q;
            logic [DW-1:0] rs;
            logic          ge;
            r  = (j == 0) ? t_r_reg : dv_r_reg[(j == 0) ? 0 : j - 1];
            dv = (j == 0) ? t_d_reg : dv_d_reg[(j == 0) ? 0 : j - 1];
            q  = (j == 0) ? '0 : dv_q_reg[(j == 0) ? 0 : j - 1];
            ge = r >= dv;
            rs = ge ? r - dv : r;
            dv_r_next[j] = {rs[DW-2:0], 1'b0};
            dv_q_next[j] = {q[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[DIV0])
        begin
            dv_r_reg[0] <= dv_r_next[0];
            dv_q_reg[0] <= dv_q_next[0];
            dv_d_reg[0] <= t_d_reg;
            dv_h_reg[0] <= t_h_reg;
            dv_l_reg[0] <= lim_reg[DIV0-1];
        end
        for (int j = 1; j < QW; j++)
        begin
            if (rdy[DIV0+j])
            begin
                dv_r_reg[j] <= dv_r_next[j];
                dv_q_reg[j] <= dv_q_next[j];
                dv_d_reg[j] <= dv_d_reg[j-1];
                dv_h_reg[j] <= dv_h_reg[j-1];
                dv_l_reg[j] <= dv_l_reg[j-1];
            end
        end
    end

    // output stage: exact limit compare
    always_comb
    begin
        logic [QW-1:0] q;
        logic [CW-1:0] lim;
        logic          exact;
        q     = dv_q_reg[QW-1];
        lim   = dv_l_reg[QW-1];
        exact = dv_r_reg[QW-1] == '0;
        hit_next = dv_h_reg[QW-1] && (q < lim || (q == lim && exact));
        hit_distance_next = hit_next ? q : lim;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG-1])
        begin
            hit_reg          <= hit_next;
            hit_distance_reg <= hit_distance_next;
        end
    end

    assign res_valid    = vld_reg[NSTG-1];
    assign hit          = hit_reg;
    assign hit_distance = hit_distance_reg;

endmodule
`default_nettype wire

// ===== sv/rti_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks for the ray/triangle test, bound to the top level.
// ----------------------------------------------------------------------------
module rti_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    tri_stall,
    input wire logic                    res_valid,
    input wire logic                    res_stall,
    input wire logic [rti_pkg::CW-1:0]  hit_distance,
    input wire logic                    hit
);
    import rti_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // input only stalls when the whole pipe is backed up by the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tri_stall |-> (res_valid && res_stall))
        else $error("input stalled without output back-pressure");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(hit_distance) && $stable(hit))
        else $error("result changed while stalled");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tri_stall    (tri_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .hit_distance (hit_distance),
    .hit          (hit)
);
`default_nettype wire

// ===== tb/ray_triangle_intersect_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top_tb
// Drives directed and random triangle requests against a programmed ray and
// compares every result with an exact wide-integer intersection predictor.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top_tb;
    import rti_pkg::*;

    localparam logic [IXW-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [IXW-1:0] REG_UNUSED_7 = 3'd7;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [8:0][CW-1:0] v;
        logic [CW-1:0]      lim;
    } tri_req_t;

    typedef struct packed {
        logic [CW-1:0] distance;
        logic          h;
    } hit_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IXW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic tri_valid = 1'b0;
    logic tri_stall;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [CW-1:0] hit_distance;
    logic hit;
    tri_req_t drv = '0;

    logic signed [CW-1:0] ray_org [3] = '{0, 0, 0};
    logic signed [CW-1:0] ray_dir [3] = '{0, 0, 0};

    tri_req_t pending [$];
    hit_res_t hits_due [$];
    int errors = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    always #5 clk = ~clk;

    ray_triangle_intersect_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .tri_valid(tri_valid), .tri_stall(tri_stall),
        .vertex_a_x(drv.v[0]), .vertex_a_y(drv.v[1]), .vertex_a_z(drv.v[2]),
        .vertex_b_x(drv.v[3]), .vertex_b_y(drv.v[4]), .vertex_b_z(drv.v[5]),
        .vertex_c_x(drv.v[6]), .vertex_c_y(drv.v[7]), .vertex_c_z(drv.v[8]),
        .t_limit(drv.lim),
        .res_valid(res_valid), .res_stall(res_stall),
        .hit_distance(hit_distance), .hit(hit)
    );

    function automatic void predict_hit(input tri_req_t r, output logic [CW-1:0] distance,
                                        output logic h);
        logic signed [127:0] o [3], dr [3], a [3], b [3], c [3];
        logic signed [127:0] e1 [3], e2 [3], d [3], s1 [3], s2 [3];
        logic signed [127:0] k, n1, n2, nt, nk, nnt;
        logic [191:0] mk, mt, quo, rmd;
        h = 1'b0;
        distance = r.lim;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = 128'(ray_org[i]);
            dr[i] = 128'(ray_dir[i]);
            a[i] = 128'($signed(r.v[i]));
            b[i] = 128'($signed(r.v[3+i]));
            c[i] = 128'($signed(r.v[6+i]));
            e1[i] = c[i] - a[i];
            e2[i] = b[i] - a[i];
            d[i] = o[i] - a[i];
        end
        s1[0] = dr[1] * e2[2] - dr[2] * e2[1];
        s1[1] = dr[2] * e2[0] - dr[0] * e2[2];
        s1[2] = dr[0] * e2[1] - dr[1] * e2[0];
        k = s1[0] * e1[0] + s1[1] * e1[1] + s1[2] * e1[2];
        if (k < 0)
        begin
            n1 = d[0] * s1[0] + d[1] * s1[1] + d[2] * s1[2];
            s2[0] = d[1] * e1[2] - d[2] * e1[1];
            s2[1] = d[2] * e1[0] - d[0] * e1[2];
            s2[2] = d[0] * e1[1] - d[1] * e1[0];
            n2 = dr[0] * s2[0] + dr[1] * s2[1] + dr[2] * s2[2];
            nt = e2[0] * s2[0] + e2[1] * s2[1] + e2[2] * s2[2];
            if (n1 <= 0 && n1 >= k && n2 <= 0 && n1 + n2 >= k && nt <= 0)
            begin
                nk = -k;
                nnt = -nt;
                mk = 192'(nk);
                mt = 192'(nnt);
                if (mt < (mk << 2))
                begin
                    quo = (mt << 30) / mk;
                    rmd = (mt << 30) % mk;
                    if (quo[CW-1:0] < r.lim || (quo[CW-1:0] == r.lim && rmd == 0))
                    begin
                        h = 1'b1;
                        distance = quo[CW-1:0];
                    end
                end
            end
        end
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(input string what, input logic [CW-1:0] got,
                          input logic [CW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // request driver
    always @(posedge clk)
    begin : drive
        hit_res_t due;
        logic nv;
        if (rst_n)
        begin
            nv = tri_valid;
            if (tri_valid && !tri_stall)
            begin
                predict_hit(drv, due.distance, due.h);
                hits_due.push_back(due);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending.size() > 0)
                begin
                    drv <= pending.pop_front();
                    nv = 1'b1;
                    send_gap <= draw_gap();
                end
            end
            tri_valid <= nv;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch
        hit_res_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (hits_due.size() == 0)
                    report("unexpected result", hit_distance, '0);
                else
                begin
                    want = hits_due.pop_front();
                    if (hit_distance !== want.distance)
                        report("hit_distance", hit_distance, want.distance);
                    if (hit !== want.h)
                        report("hit", CW'(hit), CW'(want.h));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                stall_left <= draw_gap();
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((tri_valid && !tri_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ray_triangle_intersect_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [IXW-1:0] idx, input logic [CW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ORG_X: ray_org[0] = val;
            REG_ORG_Y: ray_org[1] = val;
            REG_ORG_Z: ray_org[2] = val;
            REG_DIR_X: ray_dir[0] = val;
            REG_DIR_Y: ray_dir[1] = val;
            REG_DIR_Z: ray_dir[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_ray(input logic [CW-1:0] ox, oy, oz, dx, dy, dz);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
    endtask

    task automatic drain();
        while (pending.size() > 0 || tri_valid || hits_due.size() > 0)
            @(posedge clk);
    endtask

    function automatic tri_req_t noise_req();
        tri_req_t r;
        for (int i = 0; i < 9; i++)
            r.v[i] = $urandom;
        r.lim = $urandom;
        return r;
    endfunction

    function automatic tri_req_t fill_req(input logic [CW-1:0] val, input logic [CW-1:0] lim);
        tri_req_t r;
        for (int i = 0; i < 9; i++)
            r.v[i] = val;
        r.lim = lim;
        return r;
    endfunction

    // triangle around point p; lim_mode 0 exact, 1 just below, 2 just above,
    // 3 random, 4 widest
    function automatic tri_req_t build_tri(input logic signed [63:0] p [3], input int spread,
                                           input bit front, input int lim_mode);
        tri_req_t r;
        logic [CW-1:0] q, tmp;
        logic h;
        int u, w;
        for (int i = 0; i < 3; i++)
        begin
            u = $urandom_range(0, 2 * spread) - spread;
            w = $urandom_range(0, 2 * spread) - spread;
            r.v[i] = CW'(p[i] + u);
            r.v[3+i] = CW'(p[i] + w);
            r.v[6+i] = CW'(p[i] - u - w);
        end
        r.lim = '1;
        predict_hit(r, q, h);
        if (!h || front)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tmp = r.v[3+i];
                r.v[3+i] = r.v[6+i];
                r.v[6+i] = tmp;
            end
            predict_hit(r, q, h);
        end
        case (lim_mode)
            0: r.lim = q;
            1: r.lim = q - 1;
            2: r.lim = q + 1;
            3: r.lim = $urandom;
            default: r.lim = '1;
        endcase
        if (!h && lim_mode < 3)
            r.lim = $urandom;
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_span(input int bits);
        logic signed [CW-1:0] x;
        x = $signed($urandom) >>> (CW - bits);
        return x;
    endfunction

    task automatic random_phase(input int count, input bit mid_drain);
        logic signed [63:0] p [3];
        logic signed [95:0] step;
        logic [CW-1:0] t0;
        calm = ($urandom_range(0, 3) == 0);
        set_ray(rand_span($urandom_range(8, 28)), rand_span($urandom_range(8, 28)),
                rand_span($urandom_range(8, 28)), rand_span($urandom_range(14, 27)),
                rand_span($urandom_range(14, 27)), rand_span($urandom_range(14, 27)));
        for (int n = 0; n < count; n++)
        begin
            if (mid_drain && n == count / 2)
                drain();
            if ($urandom_range(0, 9) < 3)
                pending.push_back(noise_req());
            else
            begin
                t0 = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h7fffffff);
                for (int i = 0; i < 3; i++)
                begin
                    step = $signed({1'b0, t0}) * ray_dir[i];
                    p[i] = 64'(ray_org[i] + (step >>> 30));
                end
                pending.push_back(build_tri(p, 1 << $urandom_range(2, 20), $urandom_range(0, 15) == 0,
                                            $urandom_range(0, 4)));
            end
        end
        drain();
    endtask

    initial
    begin : stimulus
        logic signed [63:0] p [3];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset ray: zero direction, every triangle misses
        pending.push_back(fill_req(32'h0, 32'h0));
        pending.push_back(fill_req(32'h80000000, 32'h0));
        pending.push_back(fill_req(32'h7fffffff, 32'hffffffff));
        pending.push_back(noise_req());
        drain();

        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff0000);
        write_reg(REG_UNUSED_6, $urandom);
        write_reg(REG_UNUSED_7, $urandom);
        p = '{0, 0, -32768};
        pending.push_back(build_tri(p, 4096, 1'b0, 0));
        pending.push_back(build_tri(p, 4096, 1'b0, 1));
        pending.push_back(build_tri(p, 4096, 1'b0, 2));
        pending.push_back(build_tri(p, 4096, 1'b1, 4));
        pending.push_back(build_tri(p, 0, 1'b0, 4));
        p = '{0, 0, 0};
        pending.push_back(build_tri(p, 65536, 1'b0, 0));
        pending.push_back(build_tri(p, 65536, 1'b0, 3));
        p = '{0, 0, -5 * 65536};
        pending.push_back(build_tri(p, 65536, 1'b0, 4));
        p = '{0, 0, -4 * 65536};
        pending.push_back(build_tri(p, 65536, 1'b0, 4));
        p = '{0, 0, -(4 * 65536 - 1)};
        pending.push_back(build_tri(p, 65536, 1'b0, 4));
        drain();

        set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        for (int n = 0; n < 4; n++)
            pending.push_back(noise_req());
        pending.push_back(fill_req(32'h7fffffff, 32'hffffffff));
        drain();
        set_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000);
        for (int n = 0; n < 4; n++)
            pending.push_back(noise_req());
        pending.push_back(fill_req(32'h80000000, 32'h0));
        drain();

        for (int ph = 0; ph < 8; ph++)
            random_phase(220, ph == 2);

        repeat (60) @(posedge clk);
        if (errors == 0 && hits_due.size() == 0)
            $display("ray_triangle_intersect_top regression: pass");
        else
            $display("ray_triangle_intersect_top regression: fail");
        $finish;
    end

endmodule
